@@ rtl/ntour_pkg.sv @@
// Shared types and constants for the nearest-neighbour tour order block.
// No dependencies; used by every other file of the block.
`default_nettype none

package ntour_pkg;

   localparam int NODE_W  = 6;
   localparam int DIST_W  = 32;
   localparam int CFG_W   = 7;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [ADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;
   localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 7'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_SOLVE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] row;
      logic [NODE_W-1:0] col;
      logic [DIST_W-1:0] distance;
      logic [NODE_W-1:0] origin;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
      logic              fallback;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic launch;
      logic emit;
      logic issue;
      logic pick;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_last;
      logic pend_last;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/ntour_ctrl.sv @@
// Sequencer for the tour order block: accepts words, steps through row scans.
// Depends on ntour_pkg for the command and status structs.
`default_nettype none

module ntour_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_kind,
   input  wire ntour_pkg::status_type  status,
   output ntour_pkg::cmd_type          cmd,
   output logic                        req_stall
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == ntour_pkg::KIND_SOLVE) begin
                  cmd.launch = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.pend_last ? ST_IDLE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ntour_dpath.sv @@
// Datapath: distance matrix memory, visited marks, row scan compare and output word.
// Depends on ntour_pkg; driven by ntour_ctrl through cmd_type.
`default_nettype none

module ntour_dpath #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ntour_pkg::cmd_type            cmd,
   output ntour_pkg::status_type              status,
   input  wire ntour_pkg::req_word_type       req_word,
   input  wire logic [ntour_pkg::CFG_W-1:0]   node_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ntour_pkg::rsp_word_type            rsp_word
);

   localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int MADDR_W = 2 * IDX_W;
   localparam int DEPTH   = 2 ** MADDR_W;

   logic [DIST_BITS-1:0] mem [DEPTH];
   logic [DIST_BITS-1:0] mem_q_ff;

   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_valid_ff;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     pend_node_ff, pend_node_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 pend_fb_ff, pend_fb_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ntour_pkg::rsp_word_type rsp_word_ff;

   logic [31:0]          row_w, col_w, nc_w, nsat_w, st_w, node_w;
   logic                 load_ok;
   logic [MADDR_W-1:0]   wr_addr, rd_addr;
   logic [IDX_W-1:0]     start_idx, pick_idx;
   logic [CNT_W-1:0]     count_nxt;

   // load address and range check
   always_comb begin
      row_w   = 32'(req_word.row);
      col_w   = 32'(req_word.col);
      load_ok = (row_w < 32'(MAX_NODES)) && (col_w < 32'(MAX_NODES));
      wr_addr = {row_w[IDX_W-1:0], col_w[IDX_W-1:0]};
      rd_addr = {cur_ff, idx_ff};
   end

   // node count and start saturation
   always_comb begin
      nc_w = 32'(node_count);
      if (nc_w == 32'd0) begin
         nsat_w = 32'd1;
      end else if (nc_w > 32'(MAX_NODES)) begin
         nsat_w = 32'(MAX_NODES);
      end else begin
         nsat_w = nc_w;
      end
      st_w = 32'(req_word.origin);
      if (st_w >= nsat_w) begin
         st_w = nsat_w - 32'd1;
      end
      start_idx = st_w[IDX_W-1:0];
   end

   assign pick_idx  = found_ff ? best_idx_ff : free_idx_ff;
   assign count_nxt = count_ff + CNT_W'(1);

   always_comb begin
      n_in          = n_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      visited_in    = visited_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      pend_node_in  = pend_node_ff;
      pend_last_in  = pend_last_ff;
      pend_fb_in    = pend_fb_ff;

      if (cmd.launch) begin
         n_in                  = CNT_W'(nsat_w);
         count_in              = CNT_W'(1);
         cur_in                = start_idx;
         visited_in            = '0;
         visited_in[start_idx] = 1'b1;
         pend_node_in          = start_idx;
         pend_last_in          = (nsat_w == 32'd1);
         pend_fb_in            = 1'b0;
      end

      if (cmd.emit) begin
         idx_in        = '0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end

      if (cmd.issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // compare the word read in the previous cycle
      if (rd_valid_ff && !visited_ff[rd_idx_ff]) begin
         if ((mem_q_ff != '0) && (!found_ff || (mem_q_ff < best_ff))) begin
            best_in     = mem_q_ff;
            best_idx_in = rd_idx_ff;
            found_in    = 1'b1;
         end
         if (!free_found_ff) begin
            free_idx_in   = rd_idx_ff;
            free_found_in = 1'b1;
         end
      end

      if (cmd.pick) begin
         visited_in[pick_idx] = 1'b1;
         cur_in               = pick_idx;
         count_in             = count_nxt;
         pend_node_in         = pick_idx;
         pend_last_in         = (count_nxt == n_ff);
         pend_fb_in           = !found_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
      node_w = 32'(pend_node_ff);
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.scan_last = (CNT_W'(idx_ff) == (n_ff - CNT_W'(1)));
   assign status.pend_last = pend_last_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // matrix memory
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         mem[wr_addr] <= DIST_BITS'(req_word.distance);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= CNT_W'(1);
         count_ff      <= '0;
         cur_ff        <= '0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         visited_ff    <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         n_ff          <= n_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= cmd.issue;
         visited_ff    <= visited_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         pend_last_ff  <= pend_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= idx_ff;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_node_ff <= pend_node_in;
      pend_fb_ff   <= pend_fb_in;
      if (cmd.emit) begin
         rsp_word_ff.node     <= node_w[ntour_pkg::NODE_W-1:0];
         rsp_word_ff.last     <= pend_last_ff;
         rsp_word_ff.fallback <= pend_fb_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/nearest_neighbor_tour_order.sv @@
// Load word: written to the matrix memory at the edge that accepts it.
// Solve word: the start node is registered into the output word first; each further node
// is found by the single read port scanning one row entry a cycle, then picked and emitted.
// Input is stalled from acceptance of a solve word until its last node word is registered.
// Synchronous reset clears control state and sets node_count to 1; the matrix is not cleared.
// Depends on ntour_pkg, ntour_ctrl and ntour_dpath.
`default_nettype none

module nearest_neighbor_tour_order #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ntour_pkg::req_word_type          req_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ntour_pkg::rsp_word_type               rsp_word,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ntour_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [ntour_pkg::DATA_W-1:0]     pwdata,
   output logic [ntour_pkg::DATA_W-1:0]          prdata,
   output logic                                  pready
);

   logic [ntour_pkg::CFG_W-1:0] node_count_ff, node_count_in;
   ntour_pkg::cmd_type          cmd;
   ntour_pkg::status_type       status;

   assign pready = 1'b1;

   always_comb begin
      node_count_in = node_count_ff;
      if (psel && penable && pwrite && (paddr == ntour_pkg::ADDR_NODE_COUNT)) begin
         node_count_in = pwdata[ntour_pkg::CFG_W-1:0];
      end
      unique case (paddr)
         ntour_pkg::ADDR_NODE_COUNT: prdata = ntour_pkg::DATA_W'(node_count_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= ntour_pkg::NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   ntour_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_word.kind),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   ntour_dpath #(
      .MAX_NODES (MAX_NODES),
      .DIST_BITS (DIST_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_word   (req_word),
      .node_count (node_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

@@ rtl/ntour_checker.sv @@
// Port-level checks for nearest_neighbor_tour_order, bound to the top level.
// Depends on ntour_pkg and the top level's port names.
`default_nettype none

module ntour_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire ntour_pkg::req_word_type req_word,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire ntour_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed or dropped");

   a_solve_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_word.kind == ntour_pkg::KIND_SOLVE)) |=> req_stall)
      else $error("input not stalled after solve word");

   a_tour_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_word.last) |-> req_stall)
      else $error("input taken before tour complete");

   a_rsp_in_tour: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word raised outside a tour");

endmodule

bind nearest_neighbor_tour_order ntour_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

@@ verif/tb_nearest_neighbor_tour_order.sv @@
`timescale 1ns / 100ps
// Testbench for nearest_neighbor_tour_order: loads distance matrices, runs tour solves
// and checks every emitted node word against a nearest-neighbour predictor held here.
// Depends on ntour_pkg and the nearest_neighbor_tour_order RTL.

module tb_nearest_neighbor_tour_order;

   localparam int MATRIX_DIM    = 64;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   ntour_pkg::req_word_type            req_word;
   logic                               rsp_valid;
   logic                               rsp_stall;
   ntour_pkg::rsp_word_type            rsp_word;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [ntour_pkg::ADDR_W-1:0]       paddr;
   logic [ntour_pkg::DATA_W-1:0]       pwdata;
   logic [ntour_pkg::DATA_W-1:0]       prdata;
   logic                               pready;

   logic [ntour_pkg::DIST_W-1:0]       distance_copy [MATRIX_DIM*MATRIX_DIM];
   bit                                 entry_loaded [MATRIX_DIM*MATRIX_DIM];
   logic [ntour_pkg::CFG_W-1:0]        node_count_copy;
   ntour_pkg::rsp_word_type            expected_tour [$];
   int                                 mismatch_count = 0;
   int                                 send_idle_pct = 0;
   int                                 stall_pct = 0;

   nearest_neighbor_tour_order dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int active_nodes();
      int n;
      n = node_count_copy;
      if (n == 0) n = 1;
      if (n > MATRIX_DIM) n = MATRIX_DIM;
      return n;
   endfunction

   // greedy tour from the start node; appends every node word it will emit
   function automatic void predict_tour(input logic [ntour_pkg::NODE_W-1:0] start_in);
      int                           n;
      int                           cur;
      int                           pick;
      int                           k;
      int                           i;
      logic [ntour_pkg::DIST_W-1:0] best;
      logic [ntour_pkg::DIST_W-1:0] d;
      bit                           found;
      bit                           seen [MATRIX_DIM];
      ntour_pkg::rsp_word_type      w;
      n = active_nodes();
      cur = (int'(start_in) >= n) ? n - 1 : int'(start_in);
      seen = '{default: 1'b0};
      seen[cur] = 1'b1;
      w.node = ntour_pkg::NODE_W'(cur);
      w.last = (n == 1);
      w.fallback = 1'b0;
      expected_tour = {expected_tour, w};
      for (k = 1; k < n; k++) begin
         found = 1'b0;
         best = '0;
         pick = 0;
         for (i = 0; i < n; i++) begin
            d = distance_copy[cur*MATRIX_DIM + i];
            if (!seen[i] && d != 0 && (!found || d < best)) begin
               found = 1'b1;
               best = d;
               pick = i;
            end
         end
         if (!found) begin
            for (i = n - 1; i >= 0; i--) if (!seen[i]) pick = i;
         end
         seen[pick] = 1'b1;
         cur = pick;
         w.node = ntour_pkg::NODE_W'(cur);
         w.last = (k == n - 1);
         w.fallback = !found;
         expected_tour = {expected_tour, w};
      end
   endfunction

   function automatic logic [ntour_pkg::DIST_W-1:0] random_distance();
      case ($urandom_range(9))
         0, 1: return '0;
         7: return '1;
         8: return $urandom;
         default: return ntour_pkg::DIST_W'($urandom_range(6, 1));
      endcase
   endfunction

   function automatic logic [ntour_pkg::CFG_W-1:0] random_node_count();
      case ($urandom_range(9))
         0: return '0;
         default: return ntour_pkg::CFG_W'($urandom_range(8, 2));
      endcase
   endfunction

   always @(posedge clock) begin : tour_monitor
      ntour_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_word.kind == ntour_pkg::KIND_LOAD) begin
               distance_copy[{req_word.row, req_word.col}] = req_word.distance;
               entry_loaded[{req_word.row, req_word.col}] = 1'b1;
            end else begin
               predict_tour(req_word.origin);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tour.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected word node %0d last %b fallback %b",
                        $time, rsp_word.node, rsp_word.last, rsp_word.fallback);
            end else begin
               want = expected_tour.pop_front();
               if (rsp_word.node !== want.node || rsp_word.last !== want.last ||
                   rsp_word.fallback !== want.fallback) begin
                  mismatch_count++;
                  $display({"%0t: expected node %0d last %b fallback %b, ",
                            "got node %0d last %b fallback %b"},
                           $time, want.node, want.last, want.fallback,
                           rsp_word.node, rsp_word.last, rsp_word.fallback);
               end
            end
         end
      end
   end

   initial begin : rsp_stall_driver
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // entered and left just after a falling edge
   task automatic send_word(input ntour_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tour.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_node_count(input logic [ntour_pkg::CFG_W-1:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ntour_pkg::ADDR_NODE_COUNT;
      pwdata <= ntour_pkg::DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      node_count_copy = value;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== ntour_pkg::DATA_W'(value)) begin
         mismatch_count++;
         $display("%0t: node_count read back, expected %0d, got %0d", $time, value, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_entry(input int r, input int c,
                             input logic [ntour_pkg::DIST_W-1:0] d);
      ntour_pkg::req_word_type w;
      w.kind = ntour_pkg::KIND_LOAD;
      w.row = ntour_pkg::NODE_W'(r);
      w.col = ntour_pkg::NODE_W'(c);
      w.distance = d;
      w.origin = ntour_pkg::NODE_W'($urandom);
      send_word(w);
   endtask

   // every entry a solve may scan must hold a written value
   task automatic cover_matrix();
      int n;
      int r;
      int c;
      n = active_nodes();
      for (r = 0; r < n; r++)
         for (c = 0; c < n; c++)
            if (!entry_loaded[r*MATRIX_DIM + c]) load_entry(r, c, random_distance());
   endtask

   task automatic solve_from(input int s);
      ntour_pkg::req_word_type w;
      cover_matrix();
      w.kind = ntour_pkg::KIND_SOLVE;
      w.row = ntour_pkg::NODE_W'($urandom);
      w.col = ntour_pkg::NODE_W'($urandom);
      w.distance = $urandom;
      w.origin = ntour_pkg::NODE_W'(s);
      send_word(w);
   endtask

   task automatic test_single_node();
      set_node_count(0);
      solve_from(0);
      solve_from(63);
      set_node_count(1);
      solve_from(5);
   endtask

   task automatic test_nearest_and_ties();
      set_node_count(4);
      load_entry(0, 1, 5);
      load_entry(0, 2, 5);
      load_entry(0, 3, '1);
      load_entry(1, 0, 1);
      load_entry(1, 2, 0);
      load_entry(1, 3, '1);
      load_entry(3, 0, 2);
      load_entry(3, 1, 2);
      load_entry(3, 2, 7);
      solve_from(0);
      solve_from(63);
   endtask

   task automatic test_no_candidate();
      set_node_count(3);
      load_entry(2, 0, 0);
      load_entry(2, 1, 0);
      load_entry(0, 1, 0);
      solve_from(2);
   endtask

   task automatic test_count_register();
      set_node_count(127);
      set_node_count(64);
      set_node_count(1);
   endtask

   task automatic test_random_traffic(input int idle_in, input int stall_in);
      int n;
      send_idle_pct = idle_in;
      stall_pct = stall_in;
      repeat (2) begin
         set_node_count(random_node_count());
         n = active_nodes();
         repeat (6) begin
            if ($urandom_range(9) < 7) begin
               if ($urandom_range(4) != 0)
                  load_entry($urandom_range(n - 1), $urandom_range(n - 1), random_distance());
               else
                  load_entry($urandom_range(63), $urandom_range(63), random_distance());
            end else begin
               solve_from(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(n - 1));
            end
         end
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      node_count_copy = ntour_pkg::NODE_COUNT_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_node();
      test_nearest_and_ties();
      test_no_candidate();
      test_count_register();
      test_random_traffic(0, 0);
      test_random_traffic(77, 0);
      test_random_traffic(0, 77);
      test_random_traffic(9, 9);
      wait_drained();
      if (mismatch_count == 0 && expected_tour.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
